// ----- sv/exp2sm_pkg.sv -----
`timescale 1ns / 1ps
package exp2sm_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 64;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_REF_MAX    = 2'd0,
    REG_MASK_SCORE = 2'd1,
    REG_MULT       = 2'd2,
    REG_T_SHIFT    = 2'd3
  } reg_index_t;

  // Fixed field widths.
  localparam int unsigned SCORE_BITS     = 32;
  localparam int unsigned MULT_BITS      = 63;
  localparam int unsigned MULT_LO_BITS   = 32;
  localparam int unsigned MULT_HI_BITS   = MULT_BITS - MULT_LO_BITS;
  localparam int unsigned SHIFT_BITS     = 6;
  localparam int unsigned PROD_BITS      = SCORE_BITS + MULT_BITS;
  localparam int unsigned WEIGHT_BITS    = 31;
  localparam int unsigned BLOCK_SUM_BITS = 48;
  localparam int unsigned IP_BITS        = 5;
  localparam int unsigned IP_LIMIT       = 31;

  // Register values after reset.
  localparam logic signed [SCORE_BITS-1:0] RESET_REF_MAX    = 32'sh0000_0000;
  localparam logic signed [SCORE_BITS-1:0] RESET_MASK_SCORE = 32'sh8000_0000;
  localparam logic [MULT_BITS-1:0]         RESET_MULT       = '0;
  localparam logic [SHIFT_BITS-1:0]        RESET_T_SHIFT    = 6'd13;

  // Constants for building the exp2 table at elaboration.
  localparam logic [63:0] LN2_Q62      = 64'h2C5C_85FD_F473_DE6B;
  localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;
  localparam int unsigned TAYLOR_TERMS = 26;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] ref_max;
    logic signed [SCORE_BITS-1:0] mask_score;
    logic [MULT_BITS-1:0]         mult;
    logic [SHIFT_BITS-1:0]        t_shift;
  } cfg_t;

  typedef struct packed {
    logic                 last;
    logic                 masked;
    logic                 is_one;
    logic [PROD_BITS-1:0] prod;
  } prod_item_t;

  typedef struct packed {
    logic                   last;
    logic                   add;
    logic [WEIGHT_BITS-1:0] weight;
  } weight_item_t;

  // Divides a Taylor term by its step number.
  function automatic logic [63:0] div_by_step(input logic [63:0] v, input int unsigned k);
    case (k)
      1:       return v;
      2:       return v / 64'd2;
      3:       return v / 64'd3;
      4:       return v / 64'd4;
      5:       return v / 64'd5;
      6:       return v / 64'd6;
      7:       return v / 64'd7;
      8:       return v / 64'd8;
      9:       return v / 64'd9;
      10:      return v / 64'd10;
      11:      return v / 64'd11;
      12:      return v / 64'd12;
      13:      return v / 64'd13;
      14:      return v / 64'd14;
      15:      return v / 64'd15;
      16:      return v / 64'd16;
      17:      return v / 64'd17;
      18:      return v / 64'd18;
      19:      return v / 64'd19;
      20:      return v / 64'd20;
      21:      return v / 64'd21;
      22:      return v / 64'd22;
      23:      return v / 64'd23;
      24:      return v / 64'd24;
      25:      return v / 64'd25;
      26:      return v / 64'd26;
      default: return v;
    endcase
  endfunction

  // One table entry: round(2^(-idx/2^fbits) * 2^lut_bits), ties up.
  // The exponential is an alternating Taylor series of e^-x in Q62.
  function automatic logic [WEIGHT_BITS-1:0] exp2_entry(input int unsigned idx,
                                                        input int unsigned fbits,
                                                        input int unsigned lut_bits);
    logic [63:0]  frac_mask;
    logic [63:0]  x;
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [63:0]  q;
    logic [127:0] wide;
    frac_mask = (64'd1 << fbits) - 64'd1;
    x = (LN2_Q62 >> fbits) * 64'(idx)
      + (((LN2_Q62 & frac_mask) * 64'(idx)) >> fbits);
    sum  = ONE_Q62;
    term = ONE_Q62;
    for (int unsigned k = 1; k <= TAYLOR_TERMS; k++) begin
      wide = {64'd0, term} * {64'd0, x};
      term = div_by_step(wide[125:62], k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    q = (sum + (64'd1 << (61 - lut_bits))) >> (62 - lut_bits);
    return q[WEIGHT_BITS-1:0];
  endfunction

endpackage

// ----- sv/exp2sm_in_if.sv -----
`timescale 1ns / 1ps
interface exp2sm_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [exp2sm_pkg::SCORE_BITS-1:0]  score;
  logic                                      last;

  modport source (output valid, output score, output last, input ready);
  modport sink (input valid, input score, input last, output ready);
endinterface

// ----- sv/exp2sm_out_if.sv -----
`timescale 1ns / 1ps
interface exp2sm_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [exp2sm_pkg::WEIGHT_BITS-1:0]       weight;
  logic [exp2sm_pkg::BLOCK_SUM_BITS-1:0]    block_sum;
  logic                                     done_res;

  modport source (output valid, output weight, output block_sum, output done_res, input ready);
  modport sink (input valid, input weight, input block_sum, input done_res, output ready);
endinterface

// ----- sv/exp2sm_cfg_if.sv -----
`timescale 1ns / 1ps
interface exp2sm_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [exp2sm_pkg::CFG_INDEX_BITS-1:0]    index;
  logic [exp2sm_pkg::CFG_DATA_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/exp2sm_mul.sv -----
`timescale 1ns / 1ps
module exp2sm_mul (
  input  logic                                    clk,
  input  logic                                    rst,
  input  exp2sm_pkg::cfg_t                        cfg,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [exp2sm_pkg::SCORE_BITS-1:0] in_score,
  input  logic                                    in_last,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output exp2sm_pkg::prod_item_t                  out_item
);
  import exp2sm_pkg::*;

  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready;

  logic signed [SCORE_BITS:0] delta_next;

  logic                    a_last, a_masked, a_one;
  logic [SCORE_BITS-1:0]   a_delta;

  logic                             b_last, b_masked, b_one;
  logic [SCORE_BITS+MULT_LO_BITS-1:0] b_pp_lo;
  logic [SCORE_BITS+MULT_HI_BITS-1:0] b_pp_hi;

  prod_item_t c_item;

  // Exact 33-bit difference; a positive delta always fits in 32 unsigned bits.
  assign delta_next = {cfg.ref_max[SCORE_BITS-1], cfg.ref_max}
                    - {in_score[SCORE_BITS-1], in_score};

  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_last   <= in_last;
      a_masked <= (in_score == cfg.mask_score);
      a_one    <= delta_next[SCORE_BITS] || (delta_next == '0);
      a_delta  <= delta_next[SCORE_BITS-1:0];
    end
    // The 32x63 product is split into a 32x32 and a 32x31 partial product.
    if (b_ready) begin
      b_last   <= a_last;
      b_masked <= a_masked;
      b_one    <= a_one;
      b_pp_lo  <= (SCORE_BITS+MULT_LO_BITS)'(a_delta)
                * (SCORE_BITS+MULT_LO_BITS)'(cfg.mult[MULT_LO_BITS-1:0]);
      b_pp_hi  <= (SCORE_BITS+MULT_HI_BITS)'(a_delta)
                * (SCORE_BITS+MULT_HI_BITS)'(cfg.mult[MULT_BITS-1:MULT_LO_BITS]);
    end
    if (c_ready) begin
      c_item.last   <= b_last;
      c_item.masked <= b_masked;
      c_item.is_one <= b_one;
      c_item.prod   <= {b_pp_hi, {MULT_LO_BITS{1'b0}}} + PROD_BITS'(b_pp_lo);
    end
  end

  assign out_valid = c_valid;
  assign out_item  = c_item;

endmodule

// ----- sv/exp2sm_lookup.sv -----
`timescale 1ns / 1ps
module exp2sm_lookup #(
  parameter int unsigned FRACTION_BITS = 11,
  parameter int unsigned UNITY_BITS    = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  exp2sm_pkg::cfg_t            cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  exp2sm_pkg::prod_item_t      in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output exp2sm_pkg::weight_item_t    out_item
);
  import exp2sm_pkg::*;

  localparam int unsigned TBL_SIZE = 1 << FRACTION_BITS;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << UNITY_BITS;

  typedef logic [WEIGHT_BITS-1:0] rom_t [TBL_SIZE];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i < TBL_SIZE; i++) begin
      r[i] = exp2_entry(i, FRACTION_BITS, UNITY_BITS);
    end
    return r;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  logic d_valid, e_valid;
  logic d_ready, e_ready;

  logic [PROD_BITS-1:0] t_val;
  logic                 t_big;

  logic                   d_last, d_masked, d_one, d_big;
  logic [IP_BITS-1:0]     d_ip;
  logic [WEIGHT_BITS-1:0] rom_q;

  weight_item_t weight_next;
  weight_item_t e_item;

  // t is fixed point with FRACTION_BITS fraction bits; integer parts of 31 and up underflow.
  assign t_val = in_item.prod >> cfg.t_shift;
  assign t_big = (|t_val[PROD_BITS-1:FRACTION_BITS+IP_BITS])
              || (t_val[FRACTION_BITS+IP_BITS-1:FRACTION_BITS] == IP_BITS'(IP_LIMIT));

  assign e_ready  = !e_valid || out_ready;
  assign d_ready  = !d_valid || e_ready;
  assign in_ready = d_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (d_ready) begin
        d_valid <= in_valid;
      end
      if (e_ready) begin
        e_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      d_last   <= in_item.last;
      d_masked <= in_item.masked;
      d_one    <= in_item.is_one;
      d_big    <= t_big;
      d_ip     <= t_val[FRACTION_BITS+IP_BITS-1:FRACTION_BITS];
      rom_q    <= EXP_ROM[t_val[FRACTION_BITS-1:0]];
    end
    if (e_ready) begin
      e_item <= weight_next;
    end
  end

  always_comb begin
    weight_next.last   = d_last;
    weight_next.add    = 1'b0;
    weight_next.weight = '0;
    if (!d_masked) begin
      if (d_one) begin
        weight_next.add    = 1'b1;
        weight_next.weight = WEIGHT_ONE;
      end else if (!d_big) begin
        weight_next.add    = 1'b1;
        weight_next.weight = rom_q >> d_ip;
      end
    end
  end

  assign out_valid = e_valid;
  assign out_item  = e_item;

endmodule

// ----- sv/exp2sm_accum.sv -----
`timescale 1ns / 1ps
module exp2sm_accum #(
  parameter int unsigned SUM_BITS = 48
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  exp2sm_pkg::weight_item_t                in_item,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [exp2sm_pkg::WEIGHT_BITS-1:0]      out_weight,
  output logic [exp2sm_pkg::BLOCK_SUM_BITS-1:0]   out_block_sum,
  output logic                                    out_done_res
);
  import exp2sm_pkg::*;

  logic [SUM_BITS-1:0] sum_acc;
  logic [SUM_BITS-1:0] sum_next;
  logic [SUM_BITS:0]   sum_wide;

  assign sum_wide = {1'b0, sum_acc} + (SUM_BITS+1)'(in_item.weight);

  // A carry out of the sum means it passed the all-ones ceiling.
  always_comb begin
    sum_next = sum_acc;
    if (in_item.add) begin
      sum_next = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sum_acc   <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (in_valid && in_ready) begin
        sum_acc <= in_item.last ? '0 : sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_weight    <= in_item.weight;
      out_block_sum <= BLOCK_SUM_BITS'(sum_next);
      out_done_res  <= in_item.last;
    end
  end

endmodule

// ----- sv/exp2_lut_softmax_weights_core.sv -----
`timescale 1ns / 1ps
// Integer softmax weight unit, base-2 form with an exp2 lookup table.
// Channels: score_ch carries one attention score and its last flag per
// transaction; result_ch returns one weight, the running block sum and
// done_res per score, in order; cfg_ch writes the reference maximum (0),
// the mask score (1), mult (2) and t_shift (3) and is always ready. Write
// registers only while no score is in flight.
// Throughput: one score per cycle unless result_ch back-pressure has filled
// every stage. The path is a six-register pipeline: delta, split partial
// products (32x32 and 32x31), product sum, shift and table ROM read,
// weight select, and the saturating block-sum accumulator.
// The table ROM is built at elaboration and needs no fill after reset.
// Reset empties the pipeline, clears the block sum and loads the register
// defaults. When result_ch stalls, items close up into empty stages and
// score_ch drops ready only once every stage holds an item.
module exp2_lut_softmax_weights_core #(
  parameter int unsigned FRACTION_BITS = 11,
  parameter int unsigned UNITY_BITS    = 30,
  parameter int unsigned SUM_BITS      = 48
) (
  input  logic          clk,
  input  logic          rst,
  exp2sm_in_if.sink     score_ch,
  exp2sm_out_if.source  result_ch,
  exp2sm_cfg_if.sink    cfg_ch
);
  import exp2sm_pkg::*;

  cfg_t cfg;

  logic         prod_valid, prod_ready;
  prod_item_t   prod_item;
  logic         wt_valid, wt_ready;
  weight_item_t wt_item;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_max    <= RESET_REF_MAX;
      cfg.mask_score <= RESET_MASK_SCORE;
      cfg.mult       <= RESET_MULT;
      cfg.t_shift    <= RESET_T_SHIFT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_REF_MAX:    cfg.ref_max    <= cfg_ch.data[SCORE_BITS-1:0];
        REG_MASK_SCORE: cfg.mask_score <= cfg_ch.data[SCORE_BITS-1:0];
        REG_MULT:       cfg.mult       <= cfg_ch.data[MULT_BITS-1:0];
        REG_T_SHIFT:    cfg.t_shift    <= cfg_ch.data[SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  exp2sm_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (score_ch.valid),
    .in_ready  (score_ch.ready),
    .in_score  (score_ch.score),
    .in_last   (score_ch.last),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_item  (prod_item)
  );

  exp2sm_lookup #(
    .FRACTION_BITS (FRACTION_BITS),
    .UNITY_BITS    (UNITY_BITS)
  ) u_lookup (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_item   (prod_item),
    .out_valid (wt_valid),
    .out_ready (wt_ready),
    .out_item  (wt_item)
  );

  exp2sm_accum #(
    .SUM_BITS (SUM_BITS)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (wt_valid),
    .in_ready      (wt_ready),
    .in_item       (wt_item),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .out_weight    (result_ch.weight),
    .out_block_sum (result_ch.block_sum),
    .out_done_res  (result_ch.done_res)
  );

`ifndef NO_ASSERTIONS
  // Input back-pressure only appears when the whole pipeline is full and blocked.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (score_ch.valid && !score_ch.ready) |-> (result_ch.valid && !result_ch.ready))
    else $error("score channel stalled while the pipeline had room");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_ch.valid)
    else $error("result valid right after reset");

  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> (result_ch.weight <= (WEIGHT_BITS'(1) << UNITY_BITS)))
    else $error("weight above one");
`endif

endmodule
